// ===== src/hrd_pkg.sv =====
// Shared types, codes and name tables for the HTTP response deframer.
`timescale 1ns / 1ps
package hrd_pkg;

	typedef enum logic [4:0] {
		PH_STATUS, PH_REASON, PH_REASON_LF, PH_HSTART, PH_HNAME,
		PH_VCL, PH_VTE, PH_VOTHER, PH_HLF, PH_HEND_LF, PH_BODY,
		PH_CSIZE, PH_CSIZE_LF, PH_CDATA, PH_CTAIL1, PH_CTAIL2,
		PH_FINAL1, PH_FINAL2, PH_IDLE
	} phase_t;

	typedef enum logic [1:0] {
		EV_BODY = 2'd0,
		EV_DONE = 2'd1,
		EV_ERROR = 2'd2
	} event_t;

	typedef enum logic [3:0] {
		ERR_NONE = 4'd0,
		ERR_VERSION = 4'd1,
		ERR_STATUS = 4'd2,
		ERR_NO_COLON = 4'd3,
		ERR_SIZE_LONG = 4'd4,
		ERR_HEX = 4'd5,
		ERR_CHUNKS = 4'd6,
		ERR_OVERFLOW = 4'd7,
		ERR_DECIMAL = 4'd8
	} err_t;

	typedef enum logic [1:0] {
		CFG_MAX_CHUNKS = 2'd0,
		CFG_MAX_SIZE_DIGITS = 2'd1,
		CFG_MAX_MESSAGE_BYTES = 2'd2
	} cfg_reg_t;

	localparam int CFG_DATA_W = 21;
	localparam logic [6:0] MAX_CHUNKS_RST = 7'd100;
	localparam logic [3:0] MAX_SIZE_DIGITS_RST = 4'd10;
	localparam logic [20:0] MAX_MESSAGE_BYTES_RST = 21'd102400;
	localparam logic [4:0] CL_NAME_LEN = 5'd14;
	localparam logic [4:0] TE_NAME_LEN = 5'd17;
	localparam logic [2:0] CODING_LEN = 3'd7;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3a;

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		to_lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic logic [7:0] cl_char(input logic [4:0] i);
		case (i)
			5'd0: cl_char = "c";
			5'd1: cl_char = "o";
			5'd2: cl_char = "n";
			5'd3: cl_char = "t";
			5'd4: cl_char = "e";
			5'd5: cl_char = "n";
			5'd6: cl_char = "t";
			5'd7: cl_char = "-";
			5'd8: cl_char = "l";
			5'd9: cl_char = "e";
			5'd10: cl_char = "n";
			5'd11: cl_char = "g";
			5'd12: cl_char = "t";
			5'd13: cl_char = "h";
			default: cl_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] te_char(input logic [4:0] i);
		case (i)
			5'd0: te_char = "t";
			5'd1: te_char = "r";
			5'd2: te_char = "a";
			5'd3: te_char = "n";
			5'd4: te_char = "s";
			5'd5: te_char = "f";
			5'd6: te_char = "e";
			5'd7: te_char = "r";
			5'd8: te_char = "-";
			5'd9: te_char = "e";
			5'd10: te_char = "n";
			5'd11: te_char = "c";
			5'd12: te_char = "o";
			5'd13: te_char = "d";
			5'd14: te_char = "i";
			5'd15: te_char = "n";
			5'd16: te_char = "g";
			default: te_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] coding_char(input logic [2:0] i);
		case (i)
			3'd0: coding_char = "c";
			3'd1: coding_char = "h";
			3'd2: coding_char = "u";
			3'd3: coding_char = "n";
			3'd4: coding_char = "k";
			3'd5: coding_char = "e";
			3'd6: coding_char = "d";
			default: coding_char = 8'h00;
		endcase
	endfunction

endpackage

// ===== src/hrd_if.sv =====
// Byte input and result channels of the HTTP response deframer.
`timescale 1ns / 1ps
interface hrd_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic start_req;
	modport source (output valid, data_byte, start_req, input ready);
	modport sink (input valid, data_byte, start_req, output ready);
endinterface

interface hrd_out_if;
	logic valid;
	logic ready;
	logic [1:0] event_res;
	logic [7:0] body_byte;
	logic [9:0] status_value;
	logic was_chunked;
	logic [31:0] body_length;
	logic [3:0] error_code;
	logic last;
	modport source (output valid, event_res, body_byte, status_value, was_chunked,
		body_length, error_code, last, input ready);
	modport sink (input valid, event_res, body_byte, status_value, was_chunked,
		body_length, error_code, last, output ready);
endinterface

// ===== src/http_response_deframer_unit.sv =====
// Top level of the HTTP/1.1 response deframer: byte parser with registered result.
//
// channel   dir  payload                                          transfer when
// in_ch     in   data_byte, start_req                             valid && ready
// out_ch    out  event_res, body_byte, status_value, was_chunked,  valid && ready
//                body_length, error_code, last
// cfg       in   cfg_we, cfg_index, cfg_data                      cfg_we
//
// One byte per cycle sustained while the result side does not stall; a transferred byte passes
// from the input register through the parser logic into the result register.
// The parser state updates in the same step as the result register, so bytes chain
// without gaps. A stalled result holds the result register and the input register.
// arst_n clears all parse state and loads the register defaults.
`timescale 1ns / 1ps
module http_response_deframer_unit #(
	parameter int LENGTH_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [hrd_pkg::CFG_DATA_W-1:0] cfg_data,
	hrd_in_if.sink in_ch,
	hrd_out_if.source out_ch
);
	import hrd_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LMAX = {LENGTH_BITS{1'b1}};
	localparam int EW = LENGTH_BITS + 4;

	// configuration
	logic [6:0] max_chunks_q;
	logic [3:0] max_size_digits_q;
	logic [20:0] max_message_bytes_q;

	// input stage
	logic s1_valid;
	logic [7:0] byte_s1;
	logic start_s1;
	logic advance;

	// parse state
	phase_t phase_q, phase_d;
	logic [3:0] linepos_q, linepos_d;
	logic [9:0] status_q, status_d;
	logic [1:0] cand_q, cand_d;
	logic [4:0] nidx_q, nidx_d;
	logic [2:0] cidx_q, cidx_d;
	logic [LENGTH_BITS-1:0] decl_q, decl_d;
	logic chunked_q, chunked_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic [3:0] ndig_q, ndig_d;
	logic [6:0] nchunk_q, nchunk_d;
	logic [20:0] msg_q, msg_d;
	logic [31:0] deliv_q, deliv_d;

	// result
	logic res_valid;
	event_t res_ev;
	logic [7:0] res_byte;
	err_t res_err;
	logic out_valid_q;
	event_t ev_q;
	logic [7:0] obyte_q;
	logic [9:0] ostatus_q;
	logic ochunked_q;
	logic [31:0] olen_q;
	err_t oerr_q;

	assign advance = s1_valid && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunks_q <= MAX_CHUNKS_RST;
			max_size_digits_q <= MAX_SIZE_DIGITS_RST;
			max_message_bytes_q <= MAX_MESSAGE_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_CHUNKS: max_chunks_q <= cfg_data[6:0];
				CFG_MAX_SIZE_DIGITS: max_size_digits_q <= cfg_data[3:0];
				CFG_MAX_MESSAGE_BYTES: max_message_bytes_q <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			start_s1 <= in_ch.start_req;
		end
	end

	always_comb begin
		logic [7:0] b;
		logic [7:0] c;
		logic [3:0] d;
		logic [EW-1:0] ext;
		logic [EW-1:0] prod;
		logic emit_done;
		b = byte_s1;
		c = to_lower(byte_s1);
		d = 4'd0;
		ext = '0;
		prod = '0;
		emit_done = 1'b0;
		phase_d = phase_q;
		linepos_d = linepos_q;
		status_d = status_q;
		cand_d = cand_q;
		nidx_d = nidx_q;
		cidx_d = cidx_q;
		decl_d = decl_q;
		chunked_d = chunked_q;
		rem_d = rem_q;
		ndig_d = ndig_q;
		nchunk_d = nchunk_q;
		msg_d = msg_q;
		deliv_d = deliv_q;
		res_valid = 1'b0;
		res_ev = EV_BODY;
		res_byte = 8'd0;
		res_err = ERR_NONE;
		if (start_s1) begin
			phase_d = PH_STATUS;
			linepos_d = '0;
			status_d = '0;
			cand_d = 2'b11;
			nidx_d = '0;
			cidx_d = '0;
			decl_d = '0;
			chunked_d = 1'b0;
			rem_d = '0;
			ndig_d = '0;
			nchunk_d = '0;
			msg_d = '0;
			deliv_d = '0;
		end
		if (phase_d == PH_IDLE) begin
			// drop bytes until the next start
		end else if (msg_d >= max_message_bytes_q) begin
			res_valid = 1'b1;
			res_ev = EV_ERROR;
			res_err = ERR_OVERFLOW;
		end else begin
			msg_d = msg_d + 21'd1;
			unique case (phase_d)
				PH_STATUS: begin
					if (linepos_d == 4'd8 || linepos_d == 4'd12) begin
						if (b != CH_SP) begin
							res_valid = 1'b1;
							res_ev = EV_ERROR;
							res_err = (linepos_d == 4'd8) ? ERR_VERSION : ERR_STATUS;
						end else if (linepos_d == 4'd12) begin
							phase_d = PH_REASON;
						end else begin
							linepos_d = linepos_d + 4'd1;
						end
					end else if (linepos_d > 4'd8) begin
						if (b < "0" || b > "9") begin
							res_valid = 1'b1;
							res_ev = EV_ERROR;
							res_err = ERR_STATUS;
						end else begin
							status_d = 10'((status_d << 3) + (status_d << 1) + 10'(b - "0"));
							linepos_d = linepos_d + 4'd1;
						end
					end else begin
						linepos_d = linepos_d + 4'd1;
					end
				end
				PH_REASON: if (b == CH_CR) phase_d = PH_REASON_LF;
				PH_REASON_LF, PH_HLF: begin
					phase_d = PH_HSTART;
					cand_d = 2'b11;
					nidx_d = '0;
				end
				PH_HSTART, PH_HNAME: begin
					if (phase_d == PH_HSTART && b == CH_CR) begin
						phase_d = PH_HEND_LF;
					end else if (b == CH_CR || b == CH_LF) begin
						res_valid = 1'b1;
						res_ev = EV_ERROR;
						res_err = ERR_NO_COLON;
					end else if (b == CH_COLON) begin
						linepos_d = '0;
						if (cand_d[0] && nidx_d == CL_NAME_LEN) begin
							phase_d = PH_VCL;
							decl_d = '0;
						end else if (cand_d[1] && nidx_d == TE_NAME_LEN) begin
							phase_d = PH_VTE;
							cidx_d = '0;
							chunked_d = 1'b0;
						end else begin
							phase_d = PH_VOTHER;
						end
					end else begin
						phase_d = PH_HNAME;
						if (nidx_d >= CL_NAME_LEN || cl_char(nidx_d) != c) cand_d[0] = 1'b0;
						if (nidx_d >= TE_NAME_LEN || te_char(nidx_d) != c) cand_d[1] = 1'b0;
						if (nidx_d != 5'd31) nidx_d = nidx_d + 5'd1;
					end
				end
				PH_VCL: begin
					if (b == CH_CR) begin
						phase_d = PH_HLF;
					end else if (b == CH_SP && linepos_d == 4'd0) begin
						// skip leading spaces
					end else if (b < "0" || b > "9") begin
						res_valid = 1'b1;
						res_ev = EV_ERROR;
						res_err = ERR_DECIMAL;
					end else begin
						linepos_d = 4'd1;
						d = 4'(b - "0");
						ext = EW'(decl_d);
						prod = (ext << 3) + (ext << 1) + EW'(d);
						decl_d = (prod > EW'(LMAX)) ? LMAX : prod[LENGTH_BITS-1:0];
					end
				end
				PH_VTE: begin
					if (b == CH_CR) begin
						chunked_d = (cidx_d == CODING_LEN);
						phase_d = PH_HLF;
					end else if (b == CH_SP && cidx_d == 3'd0) begin
						// skip leading spaces
					end else if (cidx_d < CODING_LEN && coding_char(cidx_d) == c) begin
						cidx_d = cidx_d + 3'd1;
					end else begin
						phase_d = PH_VOTHER;
					end
				end
				PH_VOTHER: if (b == CH_CR) phase_d = PH_HLF;
				PH_HEND_LF: begin
					if (chunked_d) begin
						phase_d = PH_CSIZE;
						ndig_d = '0;
						rem_d = '0;
					end else if (decl_d == '0) begin
						emit_done = 1'b1;
					end else begin
						rem_d = decl_d;
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					if (deliv_d != 32'hFFFF_FFFF) deliv_d = deliv_d + 32'd1;
					res_valid = 1'b1;
					res_byte = b;
					if (rem_d <= LENGTH_BITS'(1)) begin
						rem_d = '0;
						res_ev = EV_DONE;
					end else begin
						rem_d = rem_d - LENGTH_BITS'(1);
					end
				end
				PH_CSIZE: begin
					if (b == CH_CR) begin
						if (ndig_d == 4'd0) begin
							res_valid = 1'b1;
							res_ev = EV_ERROR;
							res_err = ERR_HEX;
						end else begin
							phase_d = PH_CSIZE_LF;
						end
					end else if (!((b >= "0" && b <= "9") || (c >= "a" && c <= "f"))) begin
						res_valid = 1'b1;
						res_ev = EV_ERROR;
						res_err = ERR_HEX;
					end else if (ndig_d >= max_size_digits_q) begin
						res_valid = 1'b1;
						res_ev = EV_ERROR;
						res_err = ERR_SIZE_LONG;
					end else begin
						d = (b <= "9") ? 4'(b - "0") : 4'(c - "a" + 8'd10);
						ndig_d = ndig_d + 4'd1;
						ext = EW'(rem_d);
						prod = (ext << 4) + EW'(d);
						rem_d = (prod > EW'(LMAX)) ? LMAX : prod[LENGTH_BITS-1:0];
					end
				end
				PH_CSIZE_LF: begin
					if (rem_d == '0) begin
						phase_d = PH_FINAL1;
					end else if (nchunk_d >= max_chunks_q) begin
						res_valid = 1'b1;
						res_ev = EV_ERROR;
						res_err = ERR_CHUNKS;
					end else begin
						nchunk_d = nchunk_d + 7'd1;
						phase_d = PH_CDATA;
					end
				end
				PH_CDATA: begin
					if (rem_d <= LENGTH_BITS'(1)) phase_d = PH_CTAIL1;
					if (deliv_d != 32'hFFFF_FFFF) deliv_d = deliv_d + 32'd1;
					if (rem_d != '0) rem_d = rem_d - LENGTH_BITS'(1);
					res_valid = 1'b1;
					res_byte = b;
				end
				PH_CTAIL1: phase_d = PH_CTAIL2;
				PH_CTAIL2: begin
					phase_d = PH_CSIZE;
					ndig_d = '0;
					rem_d = '0;
				end
				PH_FINAL1: phase_d = PH_FINAL2;
				PH_FINAL2: emit_done = 1'b1;
				default: phase_d = PH_IDLE;
			endcase
		end
		if (emit_done) begin
			res_valid = 1'b1;
			res_ev = EV_DONE;
		end
		if (res_valid && res_ev != EV_BODY) phase_d = PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STATUS;
			linepos_q <= '0;
			status_q <= '0;
			cand_q <= 2'b11;
			nidx_q <= '0;
			cidx_q <= '0;
			decl_q <= '0;
			chunked_q <= 1'b0;
			rem_q <= '0;
			ndig_q <= '0;
			nchunk_q <= '0;
			msg_q <= '0;
			deliv_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			linepos_q <= linepos_d;
			status_q <= status_d;
			cand_q <= cand_d;
			nidx_q <= nidx_d;
			cidx_q <= cidx_d;
			decl_q <= decl_d;
			chunked_q <= chunked_d;
			rem_q <= rem_d;
			ndig_q <= ndig_d;
			nchunk_q <= nchunk_d;
			msg_q <= msg_d;
			deliv_q <= deliv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			ev_q <= res_ev;
			obyte_q <= res_byte;
			ostatus_q <= status_d;
			ochunked_q <= chunked_d;
			olen_q <= deliv_d;
			oerr_q <= res_err;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.event_res = ev_q;
	assign out_ch.body_byte = obyte_q;
	assign out_ch.status_value = ostatus_q;
	assign out_ch.was_chunked = ochunked_q;
	assign out_ch.body_length = olen_q;
	assign out_ch.error_code = oerr_q;
	assign out_ch.last = (ev_q != EV_BODY);

	// an error result carries a code, any other result none
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((ev_q == EV_ERROR) == (oerr_q != ERR_NONE)))
		else $error("error code does not match event");

	// a result ending the response leaves the parser idle
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res_ev != EV_BODY) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after final result");

	// a waiting byte holds while the result side stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !advance) |=> (s1_valid && $stable(byte_s1) && $stable(start_s1)))
		else $error("input register lost a byte");

endmodule
